[design/int8_cosine_similarity_macros.svh]
// ---------------------------------------------------------------------------
// int8_cosine_similarity assertion macros
// Clocked checks used by i8cs_ctrl, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef INT8_COSINE_SIMILARITY_MACROS_SVH
`define INT8_COSINE_SIMILARITY_MACROS_SVH

// property holds at every edge
`define I8CS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define I8CS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/i8cs_pkg.sv]
// ---------------------------------------------------------------------------
// i8cs_pkg
// Types and constants of the int8 cosine similarity block.
// ---------------------------------------------------------------------------
package i8cs_pkg;

   localparam int ACC_W  = 28;   // running sum width
   localparam int HALF_W = 14;   // multiplier operand slice
   localparam int SQ_W   = 56;   // norm product and squared dot
   localparam int WIDE_W = 90;   // root search terms
   localparam int Q_W    = 16;   // quotient search bits

   typedef struct packed {
      logic signed [7:0] elem_a;
      logic signed [7:0] elem_b;
      logic              last_elem;
   } req_type;

   typedef struct packed {
      logic signed [15:0] cosine_q15;
      logic               zero_norm;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       acc_en;
      logic       mul_en;
      logic [1:0] mul_step;
      logic       srch_init;
      logic       add_en;
      logic       cmp_en;
      logic [3:0] bit_idx;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

[design/i8cs_ctrl.sv]
// ---------------------------------------------------------------------------
// i8cs_ctrl
// Sequencer: accumulate words, then run the multiply and root search steps.
// ---------------------------------------------------------------------------
`include "int8_cosine_similarity_macros.svh"

module i8cs_ctrl
   import i8cs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [1:0] mul_cnt_ff, mul_cnt_in;
   logic [3:0] bit_cnt_ff, bit_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mul_cnt_ff <= '0;
         bit_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         mul_cnt_ff <= mul_cnt_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid && req_last) state_in = ST_MUL;
         ST_MUL:  if (mul_cnt_ff == 2'd3) state_in = ST_ADD;
         ST_ADD:  state_in = ST_CMP;
         ST_CMP:  state_in = (bit_cnt_ff == 4'd0) ? ST_DONE : ST_ADD;
         ST_DONE: if (status.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_cnt_in = (state_ff == ST_MUL) ? mul_cnt_ff + 2'd1 : 2'd0;
      bit_cnt_in = bit_cnt_ff;
      if (state_ff == ST_MUL) begin
         bit_cnt_in = 4'hF;
      end else if (state_ff == ST_CMP) begin
         bit_cnt_in = bit_cnt_ff - 4'd1;
      end
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.mul_step  = mul_cnt_ff;
      cmd.bit_idx   = bit_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.acc_en = req_valid;
         end
         ST_MUL: begin
            cmd.mul_en    = 1'b1;
            cmd.srch_init = 1'b1;
         end
         ST_ADD:  cmd.add_en = 1'b1;
         ST_CMP:  cmd.cmp_en = 1'b1;
         ST_DONE: cmd.out_load = status.out_free;
         default: req_ready = 1'b0;
      endcase
   end

   `I8CS_ASSERT_NEXT(a_last_starts, req_valid && req_ready && req_last, state_ff == ST_MUL,
      "last word did not start the search")
   `I8CS_ASSERT_NEXT(a_search_ends, state_ff == ST_CMP && bit_cnt_ff == 4'd0,
      state_ff == ST_DONE, "search did not end after the low bit")
   `I8CS_ASSERT_NEXT(a_done_holds, state_ff == ST_DONE && !status.out_free,
      state_ff == ST_DONE, "result dropped while output busy")

endmodule

[design/i8cs_dpath.sv]
// ---------------------------------------------------------------------------
// i8cs_dpath
// Running sums, shared 28x14 multiplier, bitwise root-quotient search.
// ---------------------------------------------------------------------------
module i8cs_dpath
   import i8cs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic [ACC_W-1:0]  dot_acc_ff, na_acc_ff, nb_acc_ff;
   logic [ACC_W-1:0]  dot_w_ff, na_w_ff, nb_w_ff;
   logic signed [15:0] ab_prod, aa_prod, bb_prod;
   logic [ACC_W-1:0]  dot_sum, na_sum, nb_sum;

   assign ab_prod = req.elem_a * req.elem_b;
   assign aa_prod = req.elem_a * req.elem_a;
   assign bb_prod = req.elem_b * req.elem_b;
   assign dot_sum = dot_acc_ff + {{(ACC_W-16){ab_prod[15]}}, ab_prod};
   assign na_sum  = na_acc_ff + {{(ACC_W-15){1'b0}}, aa_prod[14:0]};
   assign nb_sum  = nb_acc_ff + {{(ACC_W-15){1'b0}}, bb_prod[14:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_acc_ff <= '0;
         na_acc_ff  <= '0;
         nb_acc_ff  <= '0;
      end else if (cmd.acc_en) begin
         // clear on the last word, hand the totals to the search
         dot_acc_ff <= req.last_elem ? '0 : dot_sum;
         na_acc_ff  <= req.last_elem ? '0 : na_sum;
         nb_acc_ff  <= req.last_elem ? '0 : nb_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_en && req.last_elem) begin
         dot_w_ff <= dot_sum;
         na_w_ff  <= na_sum;
         nb_w_ff  <= nb_sum;
      end
   end

   logic              neg;
   logic [ACC_W-1:0]  mag;
   logic [ACC_W-1:0]  mul_x;
   logic [ACC_W-1:0]  mul_yw;
   logic [HALF_W-1:0] mul_y;
   logic [ACC_W+HALF_W-1:0] pp;
   logic [SQ_W-1:0]   prod_ff, magsq_ff;

   assign neg    = dot_w_ff[ACC_W-1];
   assign mag    = neg ? ({ACC_W{1'b0}} - dot_w_ff) : dot_w_ff;
   assign mul_x  = cmd.mul_step[1] ? mag : na_w_ff;
   assign mul_yw = cmd.mul_step[1] ? mag : nb_w_ff;
   assign mul_y  = cmd.mul_step[0] ? mul_yw[ACC_W-1:HALF_W] : mul_yw[HALF_W-1:0];
   assign pp     = mul_x * mul_y;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         case (cmd.mul_step)
            2'd0:    prod_ff  <= {{(SQ_W-ACC_W-HALF_W){1'b0}}, pp};
            2'd1:    prod_ff  <= prod_ff + {pp, {HALF_W{1'b0}}};
            2'd2:    magsq_ff <= {{(SQ_W-ACC_W-HALF_W){1'b0}}, pp};
            default: magsq_ff <= magsq_ff + {pp, {HALF_W{1'b0}}};
         endcase
      end
   end

   // find largest q with q*q*prod <= mag*mag*2^30, one bit per add/compare pair
   logic [WIDE_W-1:0] s_ff, t_ff, cand_ff, tcand_ff;
   logic [WIDE_W-1:0] r_val, prod_wide, t_sh, p_sh2k, p_shk;
   logic [Q_W-1:0]    q_ff;
   logic [4:0]        sh_t;

   assign r_val     = {{(WIDE_W-SQ_W-30){1'b0}}, magsq_ff, 30'd0};
   assign prod_wide = {{(WIDE_W-SQ_W){1'b0}}, prod_ff};
   assign sh_t      = {1'b0, cmd.bit_idx} + 5'd1;
   assign t_sh      = t_ff << sh_t;
   assign p_sh2k    = prod_wide << {cmd.bit_idx, 1'b0};
   assign p_shk     = prod_wide << cmd.bit_idx;

   always_ff @(posedge clock) begin
      if (cmd.srch_init) begin
         s_ff <= '0;
         t_ff <= '0;
         q_ff <= '0;
      end else if (cmd.cmp_en && (cand_ff <= r_val)) begin
         s_ff <= cand_ff;
         t_ff <= tcand_ff;
         q_ff[cmd.bit_idx] <= 1'b1;
      end
      if (cmd.add_en) begin
         cand_ff  <= s_ff + t_sh + p_sh2k;
         tcand_ff <= t_ff + p_shk;
      end
   end

   logic [Q_W:0]  qcap;
   logic [Q_W:0]  qneg;
   rsp_type       rsp_in;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;

   assign qcap = (q_ff > 16'd32768) ? 17'd32768 : {1'b0, q_ff};
   assign qneg = 17'd0 - qcap;

   always_comb begin
      rsp_in = '0;
      if (na_w_ff == '0 || nb_w_ff == '0) begin
         rsp_in.zero_norm = 1'b1;
      end else if (neg) begin
         rsp_in.cosine_q15 = qneg[15:0];
      end else begin
         rsp_in.cosine_q15 = (qcap > 17'd32767) ? 16'h7FFF : qcap[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

[design/int8_cosine_similarity.sv]
// ---------------------------------------------------------------------------
// int8_cosine_similarity
// Streams int8 vector pairs, gives dot / sqrt(|a|^2 |b|^2) in Q1.15.
// ---------------------------------------------------------------------------
//  channel  direction  payload   handshake
//  req      in         req_type  req_valid / req_ready
//  rsp      out        rsp_type  rsp_valid / rsp_ready
//
// A word that is not last is taken in the idle state (three 8x8 multiply-accumulates).
// A last word starts 4 passes of the shared 28x14 multiplier, then
// 16 quotient bits of one add and one compare step each, then the load.
// The output register holds a result while new words are accepted; the next
// result waits in the done state until that register frees up.
// Reset clears the sums and control; no clearing pass.
module int8_cosine_similarity
   import i8cs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   i8cs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_elem),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   i8cs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[verif/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Streams int8 vector pairs into the cosine block and checks every Q1.15
// result against a bit-exact predictor under varied idle and stall patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import i8cs_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_WAIT  = 120;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int8_cosine_similarity dut (.*);

   always #10 clock = ~clock;

   req_type    pending_words[$];
   rsp_type    expected_cosines[$];
   logic [27:0] dot_sum, norm_a_sum, norm_b_sum;
   int         error_count = 0;
   int         cycle_count = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   logic       req_fire = 1'b0;

   task automatic report(string msg);
      $display("tb_top: mismatch: %s", msg);
      error_count++;
   endtask

   // exact largest q with q*q*na*nb <= |dot|^2 * 2^30, sign of dot, limited
   function automatic rsp_type cosine_of(logic [27:0] dot, logic [27:0] na,
                                         logic [27:0] nb);
      rsp_type     r;
      logic [27:0] mag28;
      logic [127:0] prod, rhs;
      logic [16:0] lo, hi, mid;
      r = '0;
      if (na == 0 || nb == 0) begin
         r.zero_norm = 1'b1;
         return r;
      end
      mag28 = dot[27] ? (~dot + 28'd1) : dot;
      prod = 128'(na) * 128'(nb);
      rhs = (128'(mag28) * 128'(mag28)) << 30;
      lo = 0;
      hi = 17'd32768;
      while (lo < hi) begin
         mid = (lo + hi + 17'd1) >> 1;
         if (128'(mid) * 128'(mid) * prod <= rhs) lo = mid;
         else hi = mid - 17'd1;
      end
      if (dot[27]) r.cosine_q15 = 16'(-int'(lo));
      else r.cosine_q15 = (lo > 17'd32767) ? 16'sd32767 : 16'(lo);
      return r;
   endfunction

   task automatic push_word(int a, int b, bit last);
      req_type w;
      w.elem_a = 8'(a);
      w.elem_b = 8'(b);
      w.last_elem = last;
      pending_words.push_back(w);
   endtask

   task automatic push_vector(int len, int kind);
      int a, b;
      for (int i = 0; i < len; i++) begin
         a = $urandom_range(0, 255) - 128;
         case (kind)
            0: b = $urandom_range(0, 255) - 128;
            1: b = a;
            2: b = (a == -128) ? 127 : -a;
            3: begin a = 0; b = $urandom_range(0, 255) - 128; end
            default: b = $urandom_range(0, 7) - 4;
         endcase
         push_word(a, b, i == len - 1);
      end
   endtask

   // driver: change inputs on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_fire) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_data <= pending_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // predictor and checker on the rising edge
   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
      if (reset) begin
         req_fire <= 1'b0;
         dot_sum <= '0;
         norm_a_sum <= '0;
         norm_b_sum <= '0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            logic [27:0] d, na, nb;
            d  = dot_sum + 28'(int'(req_data.elem_a) * int'(req_data.elem_b));
            na = norm_a_sum + 28'(int'(req_data.elem_a) * int'(req_data.elem_a));
            nb = norm_b_sum + 28'(int'(req_data.elem_b) * int'(req_data.elem_b));
            if (req_data.last_elem) begin
               expected_cosines.push_back(cosine_of(d, na, nb));
               d = '0;
               na = '0;
               nb = '0;
            end
            dot_sum <= d;
            norm_a_sum <= na;
            norm_b_sum <= nb;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_cosines.size() == 0) begin
               report("result with none expected");
            end else begin
               want = expected_cosines.pop_front();
               if (rsp_data.cosine_q15 !== want.cosine_q15)
                  report($sformatf("cosine_q15 got %0d want %0d",
                                   rsp_data.cosine_q15, want.cosine_q15));
               if (rsp_data.zero_norm !== want.zero_norm)
                  report($sformatf("zero_norm got %0b want %0b",
                                   rsp_data.zero_norm, want.zero_norm));
            end
         end
      end
   end

   initial begin
      int idle_set[4] = '{0, 62, 0, 24};
      int stall_set[4] = '{0, 0, 62, 24};
      int len, kind;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, exact +-1.0, zero norms, single words
      push_word(127, 127, 1);
      push_word(-128, -128, 1);
      push_word(-128, 127, 1);
      push_word(127, -128, 1);
      push_word(0, 5, 1);
      push_word(-7, 0, 1);
      push_word(0, 0, 1);
      push_word(1, 2, 0);
      push_word(3, -4, 1);
      push_vector(5, 1);
      push_vector(5, 2);
      push_vector(4, 3);
      push_word(1, -1, 0);
      push_word(-1, 1, 1);

      for (int p = 0; p < 4; p++) begin
         wait (pending_words.size() == 0);
         send_idle_pct = idle_set[p];
         recv_stall_pct = stall_set[p];
         for (int n = 0; n < 325; n += len) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                              : $urandom_range(1, 16);
            kind = $urandom_range(0, 9);
            kind = (kind < 6) ? 0 : kind - 5;
            push_vector(len, kind);
         end
      end
      wait (pending_words.size() == 0 && !req_valid);
      wait (expected_cosines.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && expected_cosines.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

[int8_cosine_similarity.f]
+incdir+design
design/i8cs_pkg.sv
design/i8cs_ctrl.sv
design/i8cs_dpath.sv
design/int8_cosine_similarity.sv
verif/tb_top.sv
